### sv/sfp_pkg.sv
// sfp_pkg: shared types and constants for the sum checksum frame parser
// no dependencies; imported by the parser, top, checker and testbench
package sfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned NumAngleBytes = 6;

  // configuration register indexes
  localparam logic CfgStartMarker = 1'b0;
  localparam logic CfgAngleOffset = 1'b1;

  // configuration reset values
  localparam logic [ByteW-1:0] StartMarkerRst = 8'h3E;
  localparam logic [ByteW-1:0] AngleOffsetRst = 8'd38;

  // parser phases
  localparam logic [PhaseW-1:0] PhHunt = 3'd0;
  localparam logic [PhaseW-1:0] PhCmd  = 3'd1;
  localparam logic [PhaseW-1:0] PhLen  = 3'd2;
  localparam logic [PhaseW-1:0] PhHcs  = 3'd3;
  localparam logic [PhaseW-1:0] PhBody = 3'd4;
  localparam logic [PhaseW-1:0] PhBcs  = 3'd5;

  // result status codes
  localparam logic [StatusW-1:0] StGood    = 2'd0;
  localparam logic [StatusW-1:0] StHdrBad  = 2'd1;
  localparam logic [StatusW-1:0] StBodyBad = 2'd2;

  // packed result width: 2 + 8 + 8 + 1 + 3*16 = 67, padded to 72
  localparam int unsigned ResultBits = StatusW + 2*ByteW + 1 + 3*AngleW;
  localparam int unsigned ResultW    = ((ResultBits + 7) / 8) * 8;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic [ByteW-1:0]         command;
    logic [ByteW-1:0]         body_length;
    logic                     angles_present;
    logic signed [AngleW-1:0] roll;
    logic signed [AngleW-1:0] pitch;
    logic signed [AngleW-1:0] yaw;
  } result_t;

endpackage

### sv/sfp_parser.sv
// sfp_parser: frame state machine, checksum accumulation and angle capture
// depends on sfp_pkg; one byte is consumed per accepted transaction
module sfp_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_addr_i,
  input  logic [sfp_pkg::ByteW-1:0]  cfg_wdata_i,
  input  logic                       byte_valid_i,
  input  logic [sfp_pkg::ByteW-1:0]  byte_i,
  output logic                       res_valid_o,
  output sfp_pkg::result_t           res_o
);
  import sfp_pkg::*;

  logic [ByteW-1:0]  start_marker_q, angle_offset_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  cmd_q, cmd_d, len_q, len_d, cnt_q, cnt_d, sum_q, sum_d;
  logic [ByteW-1:0]  ang_q [NumAngleBytes];
  logic [ByteW-1:0]  ang_d [NumAngleBytes];
  logic [ByteW:0]    rel;
  logic [ByteW:0]    need_len;
  logic              present;
  logic              hdr_ok;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      angle_offset_q <= AngleOffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgStartMarker: start_marker_q <= cfg_wdata_i;
        CfgAngleOffset: angle_offset_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rel      = {1'b0, cnt_q} - {1'b0, angle_offset_q};
  assign need_len = {1'b0, angle_offset_q} + (ByteW+1)'(NumAngleBytes);
  assign present  = ({1'b0, len_q} >= need_len);
  assign hdr_ok   = (byte_i == ByteW'(cmd_q + len_q));

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    ang_d       = ang_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.command     = cmd_q;
    res_o.body_length = len_q;
    case (phase_q)
      PhHunt: begin
        if (byte_i == start_marker_q) begin
          cmd_d = '0;
          len_d = '0;
          cnt_d = '0;
          sum_d = '0;
          for (int i = 0; i < NumAngleBytes; i++) ang_d[i] = '0;
          phase_d = PhCmd;
        end
      end
      PhCmd: begin
        cmd_d   = byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        len_d   = byte_i;
        phase_d = PhHcs;
      end
      PhHcs: begin
        if (!hdr_ok) begin
          phase_d      = PhHunt;
          res_valid_o  = 1'b1;
          res_o.status = StHdrBad;
        end else begin
          phase_d = (len_q == '0) ? PhBcs : PhBody;
        end
      end
      PhBody: begin
        // rel is nonnegative and below six only inside the angle window
        for (int i = 0; i < NumAngleBytes; i++) begin
          if (rel == (ByteW+1)'(i)) ang_d[i] = byte_i;
        end
        sum_d = sum_q + byte_i;
        cnt_d = cnt_q + 1'b1;
        // the last body byte is the one that brings the count up to the length
        if (cnt_d == len_q) phase_d = PhBcs;
      end
      PhBcs: begin
        phase_d              = PhHunt;
        res_valid_o          = 1'b1;
        res_o.status         = (byte_i == sum_q) ? StGood : StBodyBad;
        res_o.angles_present = present;
        if (present) begin
          res_o.roll  = {ang_q[1], ang_q[0]};
          res_o.pitch = {ang_q[3], ang_q[2]};
          res_o.yaw   = {ang_q[5], ang_q[4]};
        end
      end
      default: phase_d = PhHunt;
    endcase
    if (!byte_valid_i) res_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      for (int i = 0; i < NumAngleBytes; i++) ang_q[i] <= '0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      ang_q   <= ang_d;
    end
  end

endmodule

### sv/sum_checksum_frame_parser_top.sv
// sum_checksum_frame_parser_top: stream wrapper around sfp_parser with a result register
// depends on sfp_pkg and sfp_parser
// a status result is registered onto m_axis in the cycle after the frame's last byte
// throughput: one byte per cycle unless a held result drops s_axis_tready; each byte is
// parsed in its accept cycle, and the result register frees up as it is taken (no bubble)
// reset: asynchronous active-low rst_ni puts the parser in start-marker hunt,
// restores start_marker = 0x3E and angle_offset = 38, and empties the result register
module sum_checksum_frame_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: index 0 start_marker, index 1 angle_offset
  input  logic                            cfg_we_i,
  input  logic                            cfg_addr_i,
  input  logic [sfp_pkg::ByteW-1:0]       cfg_wdata_i,
  // received byte stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sfp_pkg::ByteW-1:0]       s_axis_tdata,  // [7:0] rx_byte
  // status result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [9:2] command, [17:10] body_length, [18] angles_present,
  // [34:19] roll, [50:35] pitch, [66:51] yaw, [71:67] zero
  output logic [sfp_pkg::ResultW-1:0]     m_axis_tdata
);
  import sfp_pkg::*;

  logic               in_xfer;
  logic               res_valid;
  result_t            res;
  logic               out_valid_q, out_valid_d;
  logic [ResultW-1:0] out_data_q;
  logic [ResultW-1:0] res_packed;

  // a new byte goes in whenever the result register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  sfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (in_xfer),
    .byte_i       (s_axis_tdata),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // first field in the lowest bits
  assign res_packed = ResultW'({res.yaw, res.pitch, res.roll, res.angles_present,
                                res.body_length, res.command, res.status});

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded only when a result is produced
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_packed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### sv/sfp_checker.sv
// sfp_checker: port-level assertions for sum_checksum_frame_parser_top
// depends on sfp_pkg; attached to the top level by the bind below
module sfp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [sfp_pkg::ResultW-1:0] m_axis_tdata
);
  import sfp_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // an empty result register never blocks input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // header failures never report angles
  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == StHdrBad) |-> !m_axis_tdata[18])
    else $error("angles flagged on header failure");

  // absent angles read as zero, and status is a known code
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[18]) |->
      (m_axis_tdata[66:19] == '0 && m_axis_tdata[1:0] != 2'd3))
    else $error("bad status or nonzero absent angles");

endmodule

bind sum_checksum_frame_parser_top sfp_checker u_sfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/sum_checksum_frame_parser_top_tb.sv
// sum_checksum_frame_parser_top_tb: self-checking bench for the serial frame parser
// depends on sfp_pkg and sum_checksum_frame_parser_top; drives bytes, predicts every
// status report, checks each report field by field
module sum_checksum_frame_parser_top_tb;
  import sfp_pkg::*;

  localparam int HoldCycles   = 400;   // long receiver hold-off, fills the result register
  localparam int SettleCycles = 4;     // settling wait after the last byte, whose result is registered
  localparam int StallLimit   = 4000;  // cycles with no transaction before giving up
  localparam int PhaseBytes   = 130;   // random bytes queued per configuration phase
  localparam int ReportLimit  = 10;    // mismatches printed in detail

  typedef enum {FrGood, FrHdrBad, FrBodyBad, FrCut} frame_kind_e;

  // one status report as it leaves the block
  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic [ByteW-1:0]         command;
    logic [ByteW-1:0]         body_length;
    logic                     angles_present;
    logic signed [AngleW-1:0] roll;
    logic signed [AngleW-1:0] pitch;
    logic signed [AngleW-1:0] yaw;
  } frame_report_t;

  // every block input has a known value from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic               cfg_addr_i    = CfgStartMarker;
  logic [ByteW-1:0]   cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata  = '0;   // [7:0] rx_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [1:0] status, [9:2] command, [17:10] body_length, [18] angles_present,
  // [34:19] roll, [50:35] pitch, [66:51] yaw, [71:67] zero
  logic [ResultW-1:0] m_axis_tdata;

  // bytes waiting to be offered, reports waiting to arrive
  logic [ByteW-1:0]   rx_bytes_q[$];
  frame_report_t      pending_reports[$];
  int                 rx_queued      = 0;
  int                 mismatch_count = 0;
  int                 stall_cycles   = 0;

  // traffic shaping flags, set by the stimulus process at falling edges
  logic               steady_run = 1'b0;  // no idling on either side
  logic               hold_go    = 1'b0;  // request one long receiver hold-off
  int                 hold_left  = 0;

  // shadow of the parser: configuration and frame state
  logic [ByteW-1:0]   marker_cfg = StartMarkerRst;
  logic [ByteW-1:0]   offset_cfg = AngleOffsetRst;
  logic [PhaseW-1:0]  rx_phase   = PhHunt;
  logic [ByteW-1:0]   hdr_cmd    = '0;
  logic [ByteW-1:0]   hdr_len    = '0;
  logic [ByteW-1:0]   body_cnt   = '0;
  logic [ByteW-1:0]   body_sum   = '0;
  logic [ByteW-1:0]   angle_buf[NumAngleBytes];

  sum_checksum_frame_parser_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // frame end: build the report the parser owes for this frame
  function automatic void log_report(input logic [StatusW-1:0] st);
    frame_report_t rep;
    logic          present;
    present = (st != StHdrBad) && (int'(hdr_len) >= int'(offset_cfg) + 6);
    rep.status         = st;
    rep.command        = hdr_cmd;
    rep.body_length    = hdr_len;
    rep.angles_present = present;
    // angles are little-endian byte pairs, zeroed when not all six were reachable
    rep.roll  = present ? {angle_buf[1], angle_buf[0]} : '0;
    rep.pitch = present ? {angle_buf[3], angle_buf[2]} : '0;
    rep.yaw   = present ? {angle_buf[5], angle_buf[4]} : '0;
    pending_reports.push_back(rep);
  endfunction

  // advance the shadow parser by one received byte
  function automatic void track_rx_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] hdr_sum;
    int               rel;
    hdr_sum = hdr_cmd + hdr_len;
    case (rx_phase)
      PhHunt: begin
        // a marker seen while hunting opens a frame and wipes its state
        if (b == marker_cfg) begin
          hdr_cmd  = '0;
          hdr_len  = '0;
          body_cnt = '0;
          body_sum = '0;
          for (int i = 0; i < NumAngleBytes; i++) angle_buf[i] = '0;
          rx_phase = PhCmd;
        end
      end
      PhCmd: begin
        hdr_cmd  = b;
        rx_phase = PhLen;
      end
      PhLen: begin
        hdr_len  = b;
        rx_phase = PhHcs;
      end
      PhHcs: begin
        if (b != hdr_sum) begin
          rx_phase = PhHunt;
          log_report(StHdrBad);
        end else begin
          // zero length body: the next byte is already the body checksum
          rx_phase = (hdr_len == '0) ? PhBcs : PhBody;
        end
      end
      PhBody: begin
        // capture window follows the offset register as it is now
        rel = int'(body_cnt) - int'(offset_cfg);
        if (rel >= 0 && rel < NumAngleBytes) angle_buf[rel] = b;
        body_sum = body_sum + b;
        body_cnt = body_cnt + 8'd1;
        if (body_cnt == hdr_len) rx_phase = PhBcs;
      end
      PhBcs: begin
        rx_phase = PhHunt;
        log_report((b == body_sum) ? StGood : StBodyBad);
      end
      default: rx_phase = PhHunt;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // byte driver: holds a transaction until taken, idles at random otherwise
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (rx_bytes_q.size() != 0 && (steady_run || $urandom_range(0, 99) >= 31)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_bytes_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // report receiver: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_go) begin
        hold_left = HoldCycles;
        hold_go   = 1'b0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: byte transactions feed the shadow parser first, then the report
  // transaction of the same edge is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    frame_report_t got;
    frame_report_t want;
    logic          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        track_rx_byte(s_axis_tdata);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved              = 1'b1;
        got.status         = m_axis_tdata[1:0];
        got.command        = m_axis_tdata[9:2];
        got.body_length    = m_axis_tdata[17:10];
        got.angles_present = m_axis_tdata[18];
        got.roll           = m_axis_tdata[34:19];
        got.pitch          = m_axis_tdata[50:35];
        got.yaw            = m_axis_tdata[66:51];
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("unexpected report: status %0d command %h length %h", got.status,
                     got.command, got.body_length);
        end else begin
          want = pending_reports.pop_front();
          if (got.status != want.status || got.command != want.command ||
              got.body_length != want.body_length ||
              got.angles_present != want.angles_present || got.roll != want.roll ||
              got.pitch != want.pitch || got.yaw != want.yaw) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $write("report mismatch (expected/actual): status %0d/%0d command %h/%h",
                     want.status, got.status, want.command, got.command);
              $display(" length %h/%h present %b/%b roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                       want.body_length, got.body_length, want.angles_present,
                       got.angles_present, want.roll, got.roll, want.pitch, got.pitch,
                       want.yaw, got.yaw);
            end
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // watchdog: nothing moving for too long means the block hung
  initial begin
    wait (stall_cycles >= StallLimit);
    $display("FAIL sum_checksum_frame_parser_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_rx(input logic [ByteW-1:0] b);
    rx_bytes_q.push_back(b);
    rx_queued++;
  endtask

  // marker, command, length and header checksum
  task automatic queue_hdr(input logic [ByteW-1:0] cmd, input logic [ByteW-1:0] len,
                           input logic [ByteW-1:0] hcs);
    push_rx(marker_cfg);
    push_rx(cmd);
    push_rx(len);
    push_rx(hcs);
  endtask

  // one frame with random body; broken kinds corrupt a checksum or stop short
  task automatic queue_frame(input logic [ByteW-1:0] cmd, input logic [ByteW-1:0] len,
                             input frame_kind_e kind);
    logic [ByteW-1:0] hcs;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int               n;
    hcs = cmd + len;
    sum = '0;
    if (kind == FrHdrBad) begin
      queue_hdr(cmd, len, hcs ^ 8'($urandom_range(1, 255)));
    end else begin
      queue_hdr(cmd, len, hcs);
      n = (kind == FrCut) ? $urandom_range(0, int'(len)) : int'(len);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom);
        // the marker inside a body is just data
        if ($urandom_range(0, 19) == 0) b = marker_cfg;
        sum = sum + b;
        push_rx(b);
      end
      if (kind == FrGood) push_rx(sum);
      else if (kind == FrBodyBad) push_rx(sum ^ 8'($urandom_range(1, 255)));
    end
  endtask

  // mostly well-formed frames; lengths straddle the angle window when it is near
  task automatic queue_random_frame();
    int               r;
    logic [ByteW-1:0] len;
    r = $urandom_range(0, 99);
    if (offset_cfg <= 8'd16 && $urandom_range(0, 1) == 1)
      len = offset_cfg + 8'($urandom_range(5, 7));
    else
      len = 8'($urandom_range(0, 12));
    if (r < 70)      queue_frame(8'($urandom), len, FrGood);
    else if (r < 80) queue_frame(8'($urandom), len, FrBodyBad);
    else if (r < 88) queue_frame(8'($urandom), len, FrHdrBad);
    else if (r < 94) queue_frame(8'($urandom), len, FrCut);
    else repeat ($urandom_range(1, 8)) push_rx(8'($urandom));
  endtask

  // all bytes taken and all reports back, then let the last byte settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (rx_bytes_q.size() != 0 || s_axis_tvalid || pending_reports.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // register write; the shadow follows at the same edge
  task automatic write_reg(input logic addr, input logic [ByteW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CfgStartMarker) marker_cfg = data;
    else offset_cfg = data;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ByteW-1:0] mk;
    logic [ByteW-1:0] ofs;
    int               base;
    for (int i = 0; i < NumAngleBytes; i++) angle_buf[i] = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset configuration
    push_rx(8'h00);                                   // noise while hunting
    push_rx(8'hFF);
    queue_hdr(8'hFF, 8'h00, 8'hFF);                   // zero length body, good
    push_rx(8'h00);
    queue_hdr(8'h00, 8'h01, 8'h00);                   // header checksum bad
    wait_idle();

    // directed: angles at the very start of the body, marker changed to 0xff
    write_reg(CfgStartMarker, 8'hFF);
    write_reg(CfgAngleOffset, 8'h00);
    // body checksum bad while angles are present; body holds the marker value
    // roll 0x8000, pitch 0x7fff, yaw 0xff01
    queue_hdr(8'h80, 8'h06, 8'h86);
    push_rx(8'h00); push_rx(8'h80); push_rx(8'hFF);
    push_rx(8'h7F); push_rx(8'h01); push_rx(8'hFF);
    push_rx(8'h00);
    // offset moved from 0 to 1 after two body bytes
    queue_hdr(8'h07, 8'h07, 8'h0E);
    push_rx(8'h11); push_rx(8'h22);
    wait_idle();
    write_reg(CfgAngleOffset, 8'h01);
    push_rx(8'h33); push_rx(8'h44); push_rx(8'h55);
    push_rx(8'h66); push_rx(8'h77);
    push_rx(8'hDC);
    wait_idle();

    // random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          mk         = 8'($urandom);
          ofs        = 8'd0;
          steady_run = 1'b1;                          // a stretch with no idling
        end
        1: begin
          mk  = 8'h00;
          ofs = 8'd249;                               // last offset that still fits
        end
        2: begin
          mk  = 8'hFF;
          ofs = 8'd255;                               // never fits
        end
        3: begin
          mk  = 8'($urandom);
          ofs = 8'($urandom_range(0, 16));
        end
        4: begin
          mk  = 8'($urandom);
          ofs = 8'd250;
        end
        5: begin
          mk  = 8'($urandom);
          ofs = 8'($urandom_range(0, 249));
        end
        6: begin
          mk  = StartMarkerRst;
          ofs = AngleOffsetRst;
        end
        default: begin
          mk  = 8'($urandom);
          ofs = 8'($urandom_range(1, 8));
        end
      endcase
      write_reg(CfgStartMarker, mk);
      write_reg(CfgAngleOffset, ofs);
      if (p == 1) begin
        // longest body: angles present at 255, absent at 254
        queue_frame(8'($urandom), 8'd255, FrGood);
        queue_frame(8'($urandom), 8'd254, FrBodyBad);
      end
      // receiver stalls while bytes keep coming, so the input backs up
      if (p == 3) hold_go = 1'b1;
      base = rx_queued;
      while (rx_queued - base < PhaseBytes) queue_random_frame();
      // sender stops here until every report is back
      wait_idle();
      steady_run = 1'b0;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("PASS sum_checksum_frame_parser_top");
    end else begin
      $display("FAIL sum_checksum_frame_parser_top");
    end
    $finish;
  end

endmodule
